### rtl/core/wam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wam_pkg
// Shared types, register codes, reset values and helper functions for the
// weekday alarm matcher.
// ----------------------------------------------------------------------------
package wam_pkg;

	// Register file geometry.
	localparam int unsigned SLOT_REGS  = 3;
	localparam int unsigned SLOT_W     = 19;
	localparam int unsigned STAMP_W    = 27;
	localparam int unsigned SNOOZE_W   = 16;

	// Request codes.
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_SNOOZE  = 2'd1;
	localparam logic [1:0] REQ_DISMISS = 2'd2;

	// Register indexes (word address).
	localparam logic [1:0] REG_SLOT0   = 2'd0;
	localparam logic [1:0] REG_SLOT1   = 2'd1;
	localparam logic [1:0] REG_SLOT2   = 2'd2;
	localparam logic [1:0] REG_SNOOZE  = 2'd3;

	// Reset values: disabled, hour 7/8/9, minute 0, every weekday.
	localparam logic [SLOT_W-1:0] SLOT0_RST  = 19'h7F00E;
	localparam logic [SLOT_W-1:0] SLOT1_RST  = 19'h7F010;
	localparam logic [SLOT_W-1:0] SLOT2_RST  = 19'h7F012;
	localparam logic [SNOOZE_W-1:0] SNOOZE_RST = 16'd540;

	// Divide by 60 is a shift by two and a multiply by ceil(2^34 / 15).
	localparam logic [30:0] DIV15_MUL = 31'h44444445;

	// Per-tick compare data broadcast to every slot cell.
	typedef struct packed {
		logic               en;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [6:0]         day_bit;
		logic [STAMP_W-1:0] stamp;
	} wam_scan_t;

	// Data handed from one slot cell to the next.
	typedef struct packed {
		logic       due;
		logic [1:0] slot;
		logic       active;
	} wam_chain_t;

	// Monday-based mask bit for a Sunday-based weekday; seven aliases Sunday.
	function automatic logic [6:0] day_bit_of(input logic [2:0] wday);
		logic [6:0] bit_v;
		case (wday)
			3'd1: bit_v = 7'b000_0001;
			3'd2: bit_v = 7'b000_0010;
			3'd3: bit_v = 7'b000_0100;
			3'd4: bit_v = 7'b000_1000;
			3'd5: bit_v = 7'b001_0000;
			3'd6: bit_v = 7'b010_0000;
			default: bit_v = 7'b100_0000;
		endcase
		return bit_v;
	endfunction

	// Minute stamp: seconds / 60, exact for every 32-bit input.
	function automatic logic [STAMP_W-1:0] stamp_of(input logic [31:0] now);
		logic [60:0] prod;
		prod = {31'd0, now[31:2]} * {30'd0, DIV15_MUL};
		return prod[60:34];
	endfunction

endpackage

### rtl/core/wam_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wam_req_if
// Request channel: tick, snooze and dismiss transactions.
// ----------------------------------------------------------------------------
interface wam_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] unix_seconds;
	logic [4:0]  hour_now;
	logic [5:0]  minute_now;
	logic [2:0]  weekday_now;
	logic [2:0]  slot_index;

	modport source (
		output valid, req_type, unix_seconds, hour_now, minute_now,
			weekday_now, slot_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, unix_seconds, hour_now, minute_now,
			weekday_now, slot_index,
		output ready
	);
endinterface

### rtl/core/wam_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wam_res_if
// Result channel: one transaction per accepted request.
// ----------------------------------------------------------------------------
interface wam_res_if;
	logic       valid;
	logic       ready;
	logic       due_valid;
	logic [1:0] due_slot;
	logic       indicator_active;

	modport source (
		output valid, due_valid, due_slot, indicator_active,
		input  ready
	);
	modport sink (
		input  valid, due_valid, due_slot, indicator_active,
		output ready
	);
endinterface

### rtl/core/wam_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wam_cell
// One alarm slot: compares the tick against its slot register, keeps the
// minute stamp of its last firing, and passes the priority result on.
// ----------------------------------------------------------------------------
module wam_cell #(
	parameter logic [1:0] CELL_IDX = 2'd0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wam_pkg::SLOT_W-1:0]   slot_cfg,
	input  wam_pkg::wam_scan_t           scan,
	input  wam_pkg::wam_chain_t          chain_in,
	output wam_pkg::wam_chain_t          chain_out
);
	import wam_pkg::*;

	logic [STAMP_W-1:0] last_fire_q;
	logic               match;
	logic               fire;

	// Enabled, same hour and minute, day selected, not yet fired this minute.
	assign match = slot_cfg[0]
		&& (slot_cfg[5:1] == scan.hour)
		&& (slot_cfg[11:6] == scan.minute)
		&& ((slot_cfg[18:12] & scan.day_bit) != 7'd0)
		&& (last_fire_q != scan.stamp);
	assign fire = scan.en && match;

	// Every firing slot records the stamp, whether or not it is reported.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_fire_q <= '1;
		end else if (fire) begin
			last_fire_q <= scan.stamp;
		end
	end

	// The lowest firing slot wins; enabled slots keep the indicator lit.
	always_comb begin
		chain_out.due    = chain_in.due || fire;
		chain_out.slot   = (!chain_in.due && fire) ? CELL_IDX : chain_in.slot;
		chain_out.active = chain_in.active || slot_cfg[0];
	end

endmodule

### rtl/core/weekday_alarm_matcher_with_snooze.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekday_alarm_matcher_with_snooze
// Alarm compare block with a row of slot cells and a snooze deadline.
//
//   Channel | Dir | Handshake         | Contents
//   --------+-----+-------------------+-------------------------------------
//   req     | in  | valid / ready     | request type, time, slot to snooze
//   res     | out | valid / ready     | due flag, due slot, indicator
//   APB     | in  | psel/penable/...  | three slot registers, snooze length
//
// The first stage forms the minute stamp (a 30 x 31 bit multiply); the
// second stage runs the slot cell row and the snooze compare, which also
// updates the state. A new request is taken every cycle unless the result
// side stalls. A stalled result holds the second stage; ready drops only
// while both the stage and the output register are full. Reset clears all
// control state and restores the register defaults.
// ----------------------------------------------------------------------------
module weekday_alarm_matcher_with_snooze #(
	parameter int unsigned NUM_SLOTS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	wam_req_if.sink     req,
	wam_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wam_pkg::*;

	// Configuration registers.
	logic [SLOT_W-1:0]   slot_cfg_q [SLOT_REGS];
	logic [SNOOZE_W-1:0] snooze_len_q;
	logic                cfg_wr;

	// First stage.
	logic               valid_s1;
	logic [1:0]         req_type_s1;
	logic [31:0]        now_s1;
	logic [4:0]         hour_s1;
	logic [5:0]         minute_s1;
	logic [6:0]         day_bit_s1;
	logic [2:0]         slot_index_s1;
	logic [STAMP_W-1:0] stamp_s1;

	// Snooze state.
	logic        snz_pending_q;
	logic [1:0]  snz_slot_q;
	logic [31:0] snz_deadline_q;

	// Output register.
	logic       out_valid_q;
	logic       due_valid_q;
	logic [1:0] due_slot_q;
	logic       indicator_q;

	logic       advance;
	logic       take_in;
	logic       is_tick;
	logic       snz_hit;
	logic       snz_arm;
	logic       snz_clear;
	logic       pending_next;
	wam_scan_t  scan;
	wam_chain_t chain [NUM_SLOTS+1];

	// APB register file.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cfg_q[0] <= SLOT0_RST;
			slot_cfg_q[1] <= SLOT1_RST;
			slot_cfg_q[2] <= SLOT2_RST;
			snooze_len_q  <= SNOOZE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SLOT0:  slot_cfg_q[0] <= pwdata[SLOT_W-1:0];
				REG_SLOT1:  slot_cfg_q[1] <= pwdata[SLOT_W-1:0];
				REG_SLOT2:  slot_cfg_q[2] <= pwdata[SLOT_W-1:0];
				REG_SNOOZE: snooze_len_q  <= pwdata[SNOOZE_W-1:0];
				default:    snooze_len_q  <= snooze_len_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SLOT0:  prdata = {13'd0, slot_cfg_q[0]};
			REG_SLOT1:  prdata = {13'd0, slot_cfg_q[1]};
			REG_SLOT2:  prdata = {13'd0, slot_cfg_q[2]};
			REG_SNOOZE: prdata = {16'd0, snooze_len_q};
			default:    prdata = 32'd0;
		endcase
	end

	// Flow control: the second stage moves when the output register frees.
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign take_in   = req.valid && req.ready;

	// First stage: register the request with its minute stamp and day bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_type_s1   <= req.req_type;
			now_s1        <= req.unix_seconds;
			hour_s1       <= req.hour_now;
			minute_s1     <= req.minute_now;
			day_bit_s1    <= day_bit_of(req.weekday_now);
			slot_index_s1 <= req.slot_index;
			stamp_s1      <= stamp_of(req.unix_seconds);
		end
	end

	// Second stage: snooze deadline check takes priority over the scan.
	assign is_tick   = (req_type_s1 == REQ_TICK);
	assign snz_hit   = is_tick && snz_pending_q && (now_s1 >= snz_deadline_q);
	assign snz_arm   = (req_type_s1 == REQ_SNOOZE)
		&& (slot_index_s1 < 3'(NUM_SLOTS));
	assign snz_clear = snz_hit || (req_type_s1 == REQ_DISMISS);

	always_comb begin
		scan.en      = advance && is_tick && !snz_hit;
		scan.hour    = hour_s1;
		scan.minute  = minute_s1;
		scan.day_bit = day_bit_s1;
		scan.stamp   = stamp_s1;
	end

	// Row of slot cells, lowest index first.
	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		wam_cell #(
			.CELL_IDX (2'(i))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot_cfg  (slot_cfg_q[i]),
			.scan      (scan),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	// Snooze state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snz_pending_q  <= 1'b0;
			snz_slot_q     <= 2'd0;
			snz_deadline_q <= 32'd0;
		end else if (advance) begin
			if (snz_arm) begin
				snz_pending_q  <= 1'b1;
				snz_slot_q     <= slot_index_s1[1:0];
				snz_deadline_q <= now_s1 + {16'd0, snooze_len_q};
			end else if (snz_clear) begin
				snz_pending_q  <= 1'b0;
				snz_slot_q     <= 2'd0;
				snz_deadline_q <= 32'd0;
			end
		end
	end

	assign pending_next = snz_arm || (snz_pending_q && !snz_clear);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			due_valid_q <= snz_hit || (is_tick && chain[NUM_SLOTS].due);
			if (snz_hit) begin
				due_slot_q <= snz_slot_q;
			end else if (is_tick) begin
				due_slot_q <= chain[NUM_SLOTS].slot;
			end else begin
				due_slot_q <= 2'd0;
			end
			indicator_q <= pending_next || chain[NUM_SLOTS].active;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.due_valid        = due_valid_q;
	assign res.due_slot         = due_slot_q;
	assign res.indicator_active = indicator_q;

endmodule

### rtl/core/wam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wam_checker
// Port-level checks on flow control and snooze reporting, bound to the top.
// ----------------------------------------------------------------------------
module wam_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_type,
	input logic [2:0] slot_index,
	input logic       res_valid,
	input logic       res_ready,
	input logic       due_valid,
	input logic [1:0] due_slot,
	input logic       indicator_active
);
	import wam_pkg::*;

	// A stalled result transaction holds its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(due_valid)
			&& $stable(due_slot) && $stable(indicator_active))
		else $error("result changed while stalled");

	// Requests are refused only while the result side is stalled.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> res_valid && !res_ready)
		else $error("request refused without output stall");

	// With the output drained, every accepted request is followed by a result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 res_ready |=> res_valid)
		else $error("result missing after accepted request");

	// A snooze on slot zero always leaves the indicator lit.
	a_snooze_ind: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_type == REQ_SNOOZE && slot_index == 3'd0)
			##1 res_ready |=> indicator_active && !due_valid)
		else $error("snooze did not light the indicator");

endmodule

bind weekday_alarm_matcher_with_snooze wam_checker u_wam_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_type         (req.req_type),
	.slot_index       (req.slot_index),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.due_valid        (res.due_valid),
	.due_slot         (res.due_slot),
	.indicator_active (res.indicator_active)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weekday alarm matcher. A driver sends tick,
// snooze and dismiss transactions from a queue. The expected outcome of each
// transaction is worked out when the block accepts it. A monitor compares
// every result transaction with the oldest expected outcome. The alarm slots
// and the snooze length are reprogrammed over APB between phases, while the
// block is idle. Both channels see random idle and stall bursts, except in
// phases 2 and 5 and the last phase.
// ----------------------------------------------------------------------------
module testbench;
	import wam_pkg::*;

	localparam int unsigned NUM_SLOTS  = 3;
	localparam logic [1:0]  REQ_UNUSED = 2'd3;
	localparam logic [1:0]  SLOT_REG_OF [3] = '{REG_SLOT0, REG_SLOT1, REG_SLOT2};
	localparam int          PHASES     = 7;
	localparam int          PHASE_ITEMS = 233;

	// One request transaction as it goes on the wire.
	typedef struct {
		logic [1:0]  kind;
		logic [31:0] now;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  wday;
		logic [2:0]  slot;
	} alarm_req_t;

	// One result transaction.
	typedef struct {
		logic       due;
		logic [1:0] slot;
		logic       active;
	} alarm_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	wam_req_if req_ch ();
	wam_res_if res_ch ();

	weekday_alarm_matcher_with_snooze #(
		.NUM_SLOTS (NUM_SLOTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Programmed register copies and the alarm state they drive.
	logic [SLOT_W-1:0]   slot_cfg [3];
	logic [SNOOZE_W-1:0] snooze_len;
	logic [STAMP_W-1:0]  fired_stamp [3];
	logic                snooze_armed;
	logic [1:0]          snooze_for;
	logic [31:0]         snooze_due_at;

	alarm_req_t    pending_reqs [$];
	alarm_result_t awaited_results [$];
	alarm_req_t    on_wire;
	logic [31:0]   wall_clock;
	bit            idle_on;
	int            src_gap;
	int            snk_gap;
	int            mismatches;

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Work out the outcome of one request and advance the alarm state.
	function automatic alarm_result_t apply_request(input alarm_req_t rq);
		alarm_result_t outcome;
		logic [31:0]   minutes;
		logic [6:0]    day_bit;
		logic [18:0]   cfg;
		outcome = '{due: 1'b0, slot: 2'd0, active: 1'b0};
		case (rq.kind)
			REQ_TICK: begin
				if (snooze_armed && rq.now >= snooze_due_at) begin
					outcome.due = 1'b1;
					outcome.slot = snooze_for;
					snooze_armed = 1'b0;
					snooze_for = 2'd0;
					snooze_due_at = '0;
				end else begin
					minutes = rq.now / 32'd60;
					day_bit = 7'd1 << ((int'(rq.wday) + 6) % 7);
					for (int s = 0; s < NUM_SLOTS; s++) begin
						cfg = slot_cfg[s];
						if (cfg[0] && cfg[5:1] == rq.hour && cfg[11:6] == rq.minute
								&& (cfg[18:12] & day_bit) != '0
								&& fired_stamp[s] != minutes[STAMP_W-1:0]) begin
							fired_stamp[s] = minutes[STAMP_W-1:0];
							if (!outcome.due) begin
								outcome.due = 1'b1;
								outcome.slot = s[1:0];
							end
						end
					end
				end
			end
			REQ_SNOOZE: begin
				if (rq.slot < NUM_SLOTS) begin
					snooze_armed = 1'b1;
					snooze_for = rq.slot[1:0];
					snooze_due_at = rq.now + {16'd0, snooze_len};
				end
			end
			REQ_DISMISS: begin
				snooze_armed = 1'b0;
				snooze_for = 2'd0;
				snooze_due_at = '0;
			end
			default: ;
		endcase
		outcome.active = snooze_armed;
		for (int s = 0; s < NUM_SLOTS; s++)
			outcome.active |= slot_cfg[s][0];
		return outcome;
	endfunction

	// Driver: presents queued requests and records the expected outcome on
	// every accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				awaited_results.push_back(apply_request(on_wire));
				if (idle_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 18);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					on_wire = pending_reqs.pop_front();
					req_ch.req_type <= on_wire.kind;
					req_ch.unix_seconds <= on_wire.now;
					req_ch.hour_now <= on_wire.hour;
					req_ch.minute_now <= on_wire.minute;
					req_ch.weekday_now <= on_wire.wday;
					req_ch.slot_index <= on_wire.slot;
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string name, input logic [1:0] expected,
			input logic [1:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
				expected, actual);
			mismatches++;
		end
	endtask

	// Monitor: checks each result transaction and stalls the result channel.
	always @(posedge clk) begin
		alarm_result_t wanted;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual due %0b slot %0d active %0b",
						$time, res_ch.due_valid, res_ch.due_slot, res_ch.indicator_active);
					mismatches++;
				end else begin
					wanted = awaited_results.pop_front();
					report_field("due_valid", {1'b0, wanted.due}, {1'b0, res_ch.due_valid});
					report_field("due_slot", wanted.slot, res_ch.due_slot);
					report_field("indicator_active", {1'b0, wanted.active},
						{1'b0, res_ch.indicator_active});
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					snk_gap = $urandom_range(1, 18);
			end
		end
	end

	// APB write: setup cycle, then access cycle.
	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_SNOOZE)
			snooze_len = value[SNOOZE_W-1:0];
		else
			slot_cfg[index] = value[SLOT_W-1:0];
	endtask

	// Wait until every request is sent and every result has come back.
	task automatic settle();
		while (pending_reqs.size() > 0 || req_ch.valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_request(input logic [1:0] kind, input logic [31:0] now,
			input logic [4:0] hour, input logic [5:0] minute, input logic [2:0] wday,
			input logic [2:0] slot);
		pending_reqs.push_back('{kind: kind, now: now, hour: hour, minute: minute,
			wday: wday, slot: slot});
	endtask

	// Register settings per phase: the first two are the extremes.
	task automatic program_phase(input int phase);
		logic [31:0] value;
		int          pick;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			pick = $urandom_range(0, 9);
			if (phase == 0)
				value = 32'h7FFFF;
			else if (phase == 1 || pick == 8)
				value = '0;
			else if (pick < 6)
				value = {13'd0, 7'($urandom()), 6'($urandom_range(0, 59)),
					5'($urandom_range(0, 23)), 1'b1};
			else if (pick < 8)
				value = $urandom();
			else
				value = {13'd0, 7'($urandom()), 6'($urandom_range(0, 59)),
					5'($urandom_range(0, 23)), 1'b0};
			write_register(SLOT_REG_OF[s], value);
		end
		pick = $urandom_range(0, 9);
		if (phase == 0 || (phase > 1 && pick == 1))
			value = 32'hFFFF;
		else if (phase == 1 || pick == 0)
			value = '0;
		else
			value = {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 240))};
		write_register(REG_SNOOZE, value);
	endtask

	// Mostly ticks aimed at the programmed alarm times on a clock that moves
	// forward with rare jumps, plus snoozes, dismisses, unused codes and random noise.
	task automatic queue_random_requests(input int count);
		alarm_req_t rq;
		int         pick;
		int         s;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 39) == 0)
				wall_clock = $urandom();
			else
				wall_clock += $urandom_range(0, 100);
			rq.kind = REQ_TICK;
			rq.now = wall_clock;
			rq.hour = 5'($urandom_range(0, 31));
			rq.minute = 6'($urandom_range(0, 63));
			rq.wday = 3'($urandom_range(0, 7));
			rq.slot = 3'($urandom_range(0, 7));
			if (pick < 60) begin
				s = $urandom_range(0, NUM_SLOTS - 1);
				rq.hour = slot_cfg[s][5:1];
				rq.minute = slot_cfg[s][11:6];
			end else if (pick < 75) begin
				rq.kind = REQ_SNOOZE;
				if ($urandom_range(0, 4) != 0)
					rq.slot = 3'($urandom_range(0, NUM_SLOTS - 1));
			end else if (pick < 85) begin
				rq.kind = REQ_DISMISS;
			end else if (pick < 90) begin
				rq.kind = REQ_UNUSED;
				rq.now = $urandom();
			end else begin
				rq.now = $urandom();
			end
			pending_reqs.push_back(rq);
		end
	endtask

	// Main sequence: reset, directed cases, then random phases.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.unix_seconds = '0;
		req_ch.hour_now = '0;
		req_ch.minute_now = '0;
		req_ch.weekday_now = '0;
		req_ch.slot_index = '0;
		res_ch.ready = 1'b0;
		idle_on = 1'b1;
		src_gap = 0;
		snk_gap = 0;
		mismatches = 0;
		wall_clock = 32'd1680000000;
		slot_cfg = '{SLOT0_RST, SLOT1_RST, SLOT2_RST};
		snooze_len = SNOOZE_RST;
		fired_stamp = '{default: '1};
		snooze_armed = 1'b0;
		snooze_for = 2'd0;
		snooze_due_at = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: no slot enabled, snooze of 540 seconds. The snooze
		// deadline wraps past the top of the 32-bit time.
		queue_request(REQ_TICK, 32'd0, 5'd0, 6'd0, 3'd0, 3'd0);
		queue_request(REQ_SNOOZE, 32'd0, 5'd0, 6'd0, 3'd0, 3'd5);
		queue_request(REQ_SNOOZE, 32'hFFFF_FF00, 5'd0, 6'd0, 3'd0, 3'd2);
		queue_request(REQ_TICK, 32'h0000_0100, 5'd0, 6'd0, 3'd0, 3'd0);
		queue_request(REQ_TICK, 32'h0000_011C, 5'd0, 6'd0, 3'd0, 3'd0);
		queue_request(REQ_UNUSED, 32'hFFFF_FFFF, 5'd31, 6'd63, 3'd7, 3'd7);
		queue_request(REQ_SNOOZE, 32'd1000, 5'd0, 6'd0, 3'd0, 3'd1);
		queue_request(REQ_DISMISS, 32'd1000, 5'd0, 6'd0, 3'd0, 3'd0);
		queue_request(REQ_TICK, 32'hFFFF_FFFF, 5'd31, 6'd63, 3'd7, 3'd7);
		settle();

		// Slot 0 on Sundays only, slot 1 at the same time every day, slot 2
		// at the last minute of the day, and a zero-length snooze.
		write_register(REG_SLOT0, {13'd0, 7'b100_0000, 6'd30, 5'd7, 1'b1});
		write_register(REG_SLOT1, {13'd0, 7'h7F, 6'd30, 5'd7, 1'b1});
		write_register(REG_SLOT2, {13'd0, 7'h7F, 6'd59, 5'd23, 1'b1});
		write_register(REG_SNOOZE, 32'd0);
		// Two slots match: the lower one is reported, neither fires again in
		// the same minute, and weekday seven counts as Sunday.
		queue_request(REQ_TICK, 32'd1680000000, 5'd7, 6'd30, 3'd0, 3'd0);
		queue_request(REQ_TICK, 32'd1680000005, 5'd7, 6'd30, 3'd0, 3'd0);
		queue_request(REQ_TICK, 32'd1680000060, 5'd7, 6'd30, 3'd7, 3'd0);
		queue_request(REQ_TICK, 32'd1680000120, 5'd7, 6'd30, 3'd1, 3'd0);
		queue_request(REQ_TICK, 32'hFFFF_FFFF, 5'd23, 6'd59, 3'd6, 3'd0);
		// A due snooze wins over a matching slot; a later snooze replaces an
		// earlier one; an out-of-range slot is ignored.
		queue_request(REQ_SNOOZE, 32'd500, 5'd0, 6'd0, 3'd0, 3'd0);
		queue_request(REQ_TICK, 32'd500, 5'd23, 6'd59, 3'd6, 3'd0);
		queue_request(REQ_SNOOZE, 32'd10, 5'd0, 6'd0, 3'd0, 3'd2);
		queue_request(REQ_SNOOZE, 32'd20, 5'd0, 6'd0, 3'd0, 3'd1);
		queue_request(REQ_TICK, 32'd19, 5'd7, 6'd30, 3'd3, 3'd0);
		queue_request(REQ_TICK, 32'd20, 5'd0, 6'd0, 3'd0, 3'd0);
		queue_request(REQ_SNOOZE, 32'd30, 5'd0, 6'd0, 3'd0, 3'd3);
		queue_request(REQ_DISMISS, 32'd40, 5'd0, 6'd0, 3'd0, 3'd0);

		// Random phases; the last one runs without idle or stall bursts.
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			program_phase(phase);
			idle_on = (phase < PHASES - 1) && (phase % 3 != 2);
			queue_random_requests(PHASE_ITEMS);
		end
		settle();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && awaited_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#(2_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
